[rtl/png_chunk_framer_crc32_top_assert.svh]
// ----------------------------------------------------------------------------
// PNG chunk framer assertion macros
// Shared property shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PNG_CHUNK_FRAMER_CRC32_TOP_ASSERT_SVH
`define PNG_CHUNK_FRAMER_CRC32_TOP_ASSERT_SVH

// same-cycle implication
`define PCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// PNG chunk framer package
// Beat types, sequencer states and CRC-32 constants.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    FUNC_HDR  = 1'b0,
    FUNC_DATA = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [30:0] chunk_length;
    logic [31:0] chunk_type;
    logic [7:0]  data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LEN  = 2'd1,
    ST_TYPE = 2'd2,
    ST_TRL  = 2'd3
  } seq_state_e;

  // handshake between input register and sequencer
  typedef struct packed {
    logic     vld;
    in_beat_t beat;
  } item_t;

endpackage

[rtl/png_chunk_framer_crc32_top.sv]
// ----------------------------------------------------------------------------
// PNG chunk framer with CRC-32
// Header beats and payload beats in, serialized chunk bytes out.
// ----------------------------------------------------------------------------
// Serializes PNG chunks one byte per output beat. A header beat (func 0)
// yields the 31-bit length big-endian and the four type bytes: 8 bytes,
// or 12 when the length is zero since the trailer follows at once. A
// payload beat (func 1) yields its byte, so payload streams at one byte
// per clock while neither side stalls; the last payload beat adds 4 trailer
// bytes (inverted CRC-32, big-endian, chunk_end on the final byte). The rate
// is set by the single output byte lane and the sequencer that walks it:
// a new beat is taken only when the sequencer has no length, type or
// trailer bytes left. The CRC is folded byte by byte as the type
// and payload bytes go out. Payload with no open chunk is dropped with no
// output; a header while a chunk is open abandons it without a trailer.
// Stalls on either side are absorbed by the input and output registers.
module png_chunk_framer_crc32_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pcf_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pcf_pkg::out_beat_t out_data_o
);

  pcf_pkg::item_t     item;
  logic               take;
  logic               adv;
  logic               emit_vld;
  pcf_pkg::out_beat_t emit;

  // output register
  logic               ovld_q, ovld_d;
  pcf_pkg::out_beat_t odata_q;

  // sequencer may step whenever the output register is free or draining
  assign adv = !ovld_q || !out_stall_i;

  pcf_inreg u_inreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .item_o     (item)
  );

  pcf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .adv_i      (adv),
    .take_o     (take),
    .emit_vld_o (emit_vld),
    .emit_o     (emit)
  );

  always_comb begin
    ovld_d = ovld_q;
    if (adv) begin
      ovld_d = emit_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit_vld) begin
      odata_q <= emit;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

endmodule

[rtl/pcf_inreg.sv]
// ----------------------------------------------------------------------------
// PNG chunk framer input register
// One-entry holding register in front of the sequencer.
// ----------------------------------------------------------------------------
module pcf_inreg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcf_pkg::in_beat_t in_data_i,
  input  logic              take_i,
  output pcf_pkg::item_t    item_o
);

  logic              vld_q, vld_d;
  pcf_pkg::in_beat_t beat_q;
  logic              load;

  assign in_stall_o = vld_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_data_i;
    end
  end

  assign item_o.vld  = vld_q;
  assign item_o.beat = beat_q;

endmodule

[rtl/pcf_seq.sv]
// ----------------------------------------------------------------------------
// PNG chunk framer sequencer
// Walks length, type, payload and trailer bytes; keeps the running CRC.
// ----------------------------------------------------------------------------
module pcf_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcf_pkg::item_t     item_i,
  input  logic               adv_i,
  output logic               take_o,
  output logic               emit_vld_o,
  output pcf_pkg::out_beat_t emit_o
);

  // one byte of reflected CRC-32, bitwise
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (pcf_pkg::CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  // big-endian byte pick, index 0 is the top byte
  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

  pcf_pkg::seq_state_e state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [31:0]         crc_q, crc_d;
  logic [30:0]         rem_q, rem_d;
  logic                open_q, open_d;
  logic [30:0]         len_q, len_d;
  logic [31:0]         type_q, type_d;
  logic                is_hdr;

  assign take_o = item_i.vld && adv_i && (state_q == pcf_pkg::ST_IDLE);
  assign is_hdr = (item_i.beat.func == pcf_pkg::FUNC_HDR);

  // next state and datapath
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    rem_d   = rem_q;
    open_d  = open_q;
    len_d   = len_q;
    type_d  = type_q;
    if (adv_i) begin
      unique case (state_q)
        pcf_pkg::ST_IDLE: begin
          if (take_o) begin
            if (is_hdr) begin
              // new header drops any open chunk
              state_d = pcf_pkg::ST_LEN;
              cnt_d   = 2'd1;
              len_d   = item_i.beat.chunk_length;
              type_d  = item_i.beat.chunk_type;
              crc_d   = pcf_pkg::CRC_INIT;
              open_d  = 1'b0;
              rem_d   = '0;
            end else if (open_q) begin
              crc_d = crc_byte(crc_q, item_i.beat.data_byte);
              rem_d = rem_q - 31'd1;
              if (rem_q == 31'd1) begin
                state_d = pcf_pkg::ST_TRL;
                cnt_d   = 2'd0;
              end
            end
          end
        end
        pcf_pkg::ST_LEN: begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_d = pcf_pkg::ST_TYPE;
          end
        end
        pcf_pkg::ST_TYPE: begin
          crc_d = crc_byte(crc_q, byte_of(type_q, cnt_q));
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (len_q == '0) begin
              state_d = pcf_pkg::ST_TRL;
            end else begin
              state_d = pcf_pkg::ST_IDLE;
              open_d  = 1'b1;
              rem_d   = len_q;
            end
          end
        end
        pcf_pkg::ST_TRL: begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_d = pcf_pkg::ST_IDLE;
            open_d  = 1'b0;
            rem_d   = '0;
          end
        end
        default: begin
          state_d = pcf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // byte emitted this step
  always_comb begin
    emit_vld_o       = 1'b0;
    emit_o.out_byte  = '0;
    emit_o.chunk_end = 1'b0;
    unique case (state_q)
      pcf_pkg::ST_IDLE: begin
        if (take_o) begin
          if (is_hdr) begin
            emit_vld_o      = 1'b1;
            emit_o.out_byte = byte_of({1'b0, item_i.beat.chunk_length}, 2'd0);
          end else if (open_q) begin
            emit_vld_o      = 1'b1;
            emit_o.out_byte = item_i.beat.data_byte;
          end
        end
      end
      pcf_pkg::ST_LEN: begin
        emit_vld_o      = 1'b1;
        emit_o.out_byte = byte_of({1'b0, len_q}, cnt_q);
      end
      pcf_pkg::ST_TYPE: begin
        emit_vld_o      = 1'b1;
        emit_o.out_byte = byte_of(type_q, cnt_q);
      end
      pcf_pkg::ST_TRL: begin
        emit_vld_o       = 1'b1;
        emit_o.out_byte  = byte_of(~crc_q, cnt_q);
        emit_o.chunk_end = (cnt_q == 2'd3);
      end
      default: begin
        emit_vld_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcf_pkg::ST_IDLE;
      cnt_q   <= 2'd0;
      crc_q   <= pcf_pkg::CRC_INIT;
      rem_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      rem_q   <= rem_d;
      open_q  <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    type_q <= type_d;
  end

endmodule

[rtl/pcf_checker.sv]
// ----------------------------------------------------------------------------
// PNG chunk framer port checker
// Watches the top-level ports; bound onto the top level below.
// ----------------------------------------------------------------------------
`include "png_chunk_framer_crc32_top_assert.svh"

module pcf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input pcf_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pcf_pkg::out_beat_t out_data_o
);

  // stalled input beat holds
  `PCF_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i), "stalled input beat changed")

  // stalled output beat holds
  `PCF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // a trailer never runs straight into another chunk end
  `PCF_ASSERT_NEXT(a_end_gap, out_valid_o && !out_stall_i && out_data_o.chunk_end, !(out_valid_o && out_data_o.chunk_end), "back-to-back chunk end")

  // input stall only rises right after a beat was taken in
  `PCF_ASSERT_NOW(a_stall_rise, $rose(in_stall_o), $past(in_valid_i && !in_stall_o), "input stall rose with nothing held")

endmodule

bind png_chunk_framer_crc32_top pcf_checker u_pcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
